// File: rtl/core/bwavg_pkg.sv
package bwavg_pkg;

    // window length, most readings counted per average (new one included)
    localparam int WINDOW_DEF = 30;

    localparam int RD_W     = 9;
    localparam int STAT_W   = 8;
    localparam int PERIOD_W = 16;
    localparam int TICK_W   = 32;

    localparam logic [PERIOD_W-1:0] PERIOD_RST = 16'd1000;

    // status byte bits
    localparam int STAT_CHG_BIT = 7;
    localparam int STAT_BTN_BIT = 0;

    // item kinds
    localparam logic MODE_TICK = 1'b0;
    localparam logic MODE_READ = 1'b1;

endpackage

// File: rtl/core/bwavg_ram.sv
module bwavg_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 29,
    parameter int AW    = 5
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/bwavg_div.sv
// restoring divider, one quotient bit per cycle, unsigned magnitudes
module bwavg_div #(
    parameter int MAG_W = 13,
    parameter int CNT_W = 5
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [MAG_W-1:0] i_dividend,
    input  logic [CNT_W-1:0] i_divisor,
    output logic             o_done,
    output logic [MAG_W-1:0] o_quotient
);

    localparam int STEP_W = $clog2(MAG_W + 1);

    logic [STEP_W-1:0] r_step, n_step;
    logic [CNT_W:0]    r_rem, n_rem;
    logic [MAG_W-1:0]  r_quo, n_quo;
    logic [CNT_W:0]    r_div;
    logic              r_done, n_done;
    logic [CNT_W:0]    shifted;
    logic              fits;

    assign shifted = {r_rem[CNT_W-1:0], r_quo[MAG_W-1]};
    assign fits    = (shifted >= r_div);

    always_comb begin
        n_step = r_step;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_done = 1'b0;
        if (i_start) begin
            n_step = STEP_W'(MAG_W);
            n_rem  = '0;
            n_quo  = i_dividend;
        end else if (r_step != '0) begin
            n_rem  = fits ? (shifted - r_div) : shifted;
            n_quo  = {r_quo[MAG_W-2:0], fits};
            n_step = r_step - 1'b1;
            n_done = (r_step == STEP_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
            r_done <= 1'b0;
        end else begin
            r_step <= n_step;
            r_done <= n_done;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        if (i_start) begin
            r_div <= {1'b0, i_divisor};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// File: rtl/core/battery_level_window_average.sv
// A tick or a rejected reading is registered at the output in the cycle after accept.
// An accepted reading shows its result after a history scan, one history read per cycle
// through the single RAM read port, then a one bit per cycle divide, then the output
// load, which also waits out any output stall.
// Throughput: one reading word in flight at a time; ticks back to back while output drains.
// Reset (i_rst_n low, synchronous): period 1000, elapsed 0, average 0, flags 0, history
// reads as zero through per-entry valid bits, output channel empty.
module battery_level_window_average #(
    parameter int WINDOW = bwavg_pkg::WINDOW_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration
    input  logic                             i_cfg_wr_en,
    input  logic [bwavg_pkg::PERIOD_W-1:0]   i_cfg_wr_data,
    // input words
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic                             i_mode,
    input  logic signed [bwavg_pkg::RD_W-1:0] i_reading,
    input  logic [bwavg_pkg::STAT_W-1:0]     i_status_byte,
    // result words
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic signed [bwavg_pkg::RD_W-1:0] o_average,
    output logic                             o_charging,
    output logic                             o_button_down,
    output logic                             o_accepted
);

    localparam int RD_W     = bwavg_pkg::RD_W;
    localparam int TICK_W   = bwavg_pkg::TICK_W;
    localparam int PERIOD_W = bwavg_pkg::PERIOD_W;
    localparam int HIST_LEN = WINDOW - 1;
    localparam int AW       = (HIST_LEN > 1) ? $clog2(HIST_LEN) : 1;
    // |sum| never exceeds WINDOW*256 (readings are 9-bit signed, history skips negatives)
    localparam int MAG_W    = $clog2(WINDOW * 256 + 1);
    localparam int SUM_W    = MAG_W + 1;
    localparam int CNT_W    = $clog2(WINDOW + 1);

    // sequencer codes
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SUM   = 3'd1; // issue one history read per cycle
    localparam logic [2:0] S_LAST  = 3'd2; // fold last read, write new reading
    localparam logic [2:0] S_START = 3'd3; // launch divider
    localparam logic [2:0] S_DIV   = 3'd4; // wait on divider
    localparam logic [2:0] S_DONE  = 3'd5; // hand result to output register

    logic [2:0]                r_state, n_state;
    logic [PERIOD_W-1:0]       r_period;
    logic [TICK_W-1:0]         r_elapsed;
    logic signed [RD_W-1:0]    r_avg;
    logic                      r_chg;
    logic                      r_btn;

    logic [AW-1:0]             r_idx;      // history read address
    logic [AW-1:0]             r_wr_ptr;   // oldest entry, overwritten next
    logic [HIST_LEN-1:0]       r_hvld;     // entry written since reset
    logic                      r_rd_vld;   // RAM data this cycle belongs to a read
    logic                      r_hv_d;     // valid bit aligned with RAM data
    logic signed [SUM_W-1:0]   r_sum;
    logic [CNT_W-1:0]          r_cnt;
    logic signed [RD_W-1:0]    r_new;      // reading being folded in

    // output register
    logic                      r_o_valid;
    logic signed [RD_W-1:0]    r_o_avg;
    logic                      r_o_chg;
    logic                      r_o_btn;
    logic                      r_o_acc;

    logic                      slot_free;
    logic                      window_open;
    logic                      in_acc;
    logic                      take_now;   // word finishes at accept
    logic                      done_load;
    logic [RD_W-1:0]           ram_rdata;
    logic signed [RD_W-1:0]    entry;
    logic                      ram_we;
    logic [MAG_W-1:0]          div_mag;
    logic                      div_done;
    logic [MAG_W-1:0]          div_quo;
    logic [MAG_W-1:0]          avg_mag;

    assign slot_free   = !r_o_valid || i_ready;
    assign window_open = (r_elapsed > {{(TICK_W - PERIOD_W){1'b0}}, r_period});
    // an accepted reading may enter while the previous word still waits;
    // anything that answers right away needs the output slot
    assign o_ready     = (r_state == S_IDLE)
                      && (slot_free || (i_mode == bwavg_pkg::MODE_READ && window_open));
    assign in_acc      = i_valid && o_ready;
    assign take_now    = in_acc && !(i_mode == bwavg_pkg::MODE_READ && window_open);
    assign done_load   = (r_state == S_DONE) && slot_free;

    // invalid entries read as the reset value zero
    assign entry  = r_hv_d ? $signed(ram_rdata) : '0;
    assign ram_we = (r_state == S_LAST);

    bwavg_ram #(
        .WIDTH (RD_W),
        .DEPTH (HIST_LEN),
        .AW    (AW)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wr_ptr),
        .i_wdata (r_new),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    // signed divide truncating toward zero: divide magnitude, restore sign
    assign div_mag = r_sum[SUM_W-1] ? MAG_W'(-r_sum) : MAG_W'(r_sum);

    bwavg_div #(
        .MAG_W (MAG_W),
        .CNT_W (CNT_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == S_START),
        .i_dividend (div_mag),
        .i_divisor  (r_cnt),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    assign avg_mag = r_sum[SUM_W-1] ? (-div_quo) : div_quo;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc && !take_now) begin
                    n_state = S_SUM;
                end
            end
            S_SUM: begin
                if (r_idx == AW'(HIST_LEN - 1)) begin
                    n_state = S_LAST;
                end
            end
            S_LAST:  n_state = S_START;
            S_START: n_state = S_DIV;
            S_DIV: begin
                if (div_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_period  <= bwavg_pkg::PERIOD_RST;
            r_elapsed <= '0;
            r_avg     <= '0;
            r_chg     <= 1'b0;
            r_btn     <= 1'b0;
            r_wr_ptr  <= '0;
            r_hvld    <= '0;
            r_rd_vld  <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= (r_state == S_SUM);

            if (i_cfg_wr_en) begin
                r_period <= i_cfg_wr_data;
            end

            if (in_acc) begin
                if (i_mode == bwavg_pkg::MODE_TICK) begin
                    if (r_elapsed != '1) begin
                        r_elapsed <= r_elapsed + 1'b1;
                    end
                end else begin
                    r_chg <= i_status_byte[bwavg_pkg::STAT_CHG_BIT];
                    r_btn <= i_status_byte[bwavg_pkg::STAT_BTN_BIT];
                    if (window_open) begin
                        r_elapsed <= r_elapsed - {{(TICK_W - PERIOD_W){1'b0}}, r_period};
                    end
                end
            end

            if (r_state == S_LAST) begin
                r_hvld[r_wr_ptr] <= 1'b1;
                r_wr_ptr <= (r_wr_ptr == AW'(HIST_LEN - 1)) ? '0 : r_wr_ptr + 1'b1;
            end

            if (r_state == S_DIV && div_done) begin
                r_avg <= $signed(avg_mag[RD_W-1:0]);
            end

            if (take_now) begin
                r_o_valid <= 1'b1;
            end else if (done_load) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // datapath, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_acc && !take_now) begin
            r_new <= i_reading;
            r_sum <= SUM_W'(i_reading);
            r_cnt <= CNT_W'(1);
            r_idx <= '0;
        end else begin
            // address holds at the last entry once the scan is through
            if (r_state == S_SUM && r_idx != AW'(HIST_LEN - 1)) begin
                r_idx <= r_idx + 1'b1;
            end
            // non-negative history entries join the average
            if (r_rd_vld && !entry[RD_W-1]) begin
                r_sum <= r_sum + SUM_W'(entry);
                r_cnt <= r_cnt + 1'b1;
            end
        end
        r_hv_d <= r_hvld[r_idx];

        if (take_now) begin
            r_o_avg <= r_avg;
            r_o_acc <= 1'b0;
            if (i_mode == bwavg_pkg::MODE_READ) begin
                r_o_chg <= i_status_byte[bwavg_pkg::STAT_CHG_BIT];
                r_o_btn <= i_status_byte[bwavg_pkg::STAT_BTN_BIT];
            end else begin
                r_o_chg <= r_chg;
                r_o_btn <= r_btn;
            end
        end else if (done_load) begin
            r_o_avg <= r_avg;
            r_o_chg <= r_chg;
            r_o_btn <= r_btn;
            r_o_acc <= 1'b1;
        end
    end

    assign o_valid       = r_o_valid;
    assign o_average     = r_o_avg;
    assign o_charging    = r_o_chg;
    assign o_button_down = r_o_btn;
    assign o_accepted    = r_o_acc;

    // count stays within the window
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LAST || r_state == S_START || r_state == S_DIV)
        |-> (r_cnt != '0 && r_cnt <= CNT_W'(WINDOW)))
        else $error("sample count out of range");

    // divider finishes only while the sequencer waits on it
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> r_state == S_DIV)
        else $error("divider done outside wait state");

    // a finished average is always presented as an accepted word
    a_done_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done_load |=> (r_o_valid && r_o_acc && r_state == S_IDLE))
        else $error("average not delivered");

    // elapsed time holds at its maximum
    a_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_mode == bwavg_pkg::MODE_TICK && r_elapsed == '1) |=> r_elapsed == '1)
        else $error("elapsed time wrapped");

    // the history RAM is written once per accepted reading
    a_wr_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |=> !ram_we)
        else $error("history written twice");

endmodule

// File: bench/tb_battery_level_window_average.sv
`timescale 1ns / 1ps

module tb_battery_level_window_average;

    localparam int RD_W     = bwavg_pkg::RD_W;
    localparam int STAT_W   = bwavg_pkg::STAT_W;
    localparam int PERIOD_W = bwavg_pkg::PERIOD_W;
    localparam int TICK_W   = bwavg_pkg::TICK_W;
    localparam logic [PERIOD_W-1:0] PERIOD_RST = bwavg_pkg::PERIOD_RST;
    localparam int STAT_CHG_BIT = bwavg_pkg::STAT_CHG_BIT;
    localparam int STAT_BTN_BIT = bwavg_pkg::STAT_BTN_BIT;
    localparam logic MODE_TICK  = bwavg_pkg::MODE_TICK;
    localparam logic MODE_READ  = bwavg_pkg::MODE_READ;

    localparam int HIST_LEN  = bwavg_pkg::WINDOW_DEF - 1;   // history holds the older readings
    localparam int RUN_LIMIT = 2_000_000;        // cycles; far above the slowest clean run
    localparam int TAIL_WAIT = 100;              // covers the history scan and divide path

    // one input word and one result word, at the port widths
    typedef struct {
        logic                     mode;
        logic signed [RD_W-1:0]   reading;
        logic [STAT_W-1:0]        status;
    } t_word;

    typedef struct {
        logic signed [RD_W-1:0]   average;
        logic                     charging;
        logic                     button_down;
        logic                     accepted;
    } t_level;

    // DUT ports; every input starts at a known value
    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_cfg_wr_en = 1'b0;
    logic [PERIOD_W-1:0]        i_cfg_wr_data = '0;
    logic                       i_valid = 1'b0;
    logic                       o_ready;
    logic                       i_mode = MODE_TICK;
    logic signed [RD_W-1:0]     i_reading = '0;
    logic [STAT_W-1:0]          i_status_byte = '0;
    logic                       o_valid;
    logic                       i_ready = 1'b0;
    logic signed [RD_W-1:0]     o_average;
    logic                       o_charging;
    logic                       o_button_down;
    logic                       o_accepted;

    battery_level_window_average dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_mode        (i_mode),
        .i_reading     (i_reading),
        .i_status_byte (i_status_byte),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_average     (o_average),
        .o_charging    (o_charging),
        .o_button_down (o_button_down),
        .o_accepted    (o_accepted)
    );

    // ------------------------------------------------------------------
    // Shadow copy of the block's state, advanced once per accepted word
    // ------------------------------------------------------------------
    logic [PERIOD_W-1:0]        period_cfg = PERIOD_RST;
    logic [TICK_W-1:0]          elapsed_cnt = '0;
    logic signed [RD_W-1:0]     hist [HIST_LEN];
    logic signed [RD_W-1:0]     avg_lvl = '0;
    logic                       chg_flag = 1'b0;
    logic                       btn_flag = 1'b0;

    t_word  word_q[$];      // words waiting to be driven
    t_level level_q[$];     // predicted result words, oldest first
    t_word  cur_word;       // word currently on the input port
    t_level got_lvl;
    t_level exp_lvl;
    int     send_hold = 0;  // input-side idle cycles left
    int     ready_hold = 0; // output-side stall cycles left
    int     ready_gap;
    int     errors = 0;
    int     cycle_cnt = 0;
    bit     no_idle = 1'b0; // set for whole phases: back-to-back traffic

    initial begin
        for (int i = 0; i < HIST_LEN; i++) hist[i] = '0;
    end

    // Next result word for one input word. Ticks only move time; a reading
    // always refreshes the flags, and enters the window only once elapsed
    // time is strictly past the period.
    function automatic t_level predict_level(t_word w);
        t_level r;
        int     sum;
        int     cnt;
        r.accepted = 1'b0;
        if (w.mode == MODE_TICK) begin
            if (elapsed_cnt != '1) elapsed_cnt = elapsed_cnt + 1;   // saturates
        end else begin
            if (elapsed_cnt > TICK_W'(period_cfg)) begin
                // new reading always counts, even when negative
                sum = int'(w.reading);
                cnt = 1;
                for (int i = 0; i < HIST_LEN; i++) begin
                    if (hist[i] >= 0) begin
                        sum += int'(hist[i]);
                        cnt++;
                    end
                end
                for (int i = 0; i + 1 < HIST_LEN; i++) hist[i] = hist[i + 1];
                hist[HIST_LEN - 1] = w.reading;
                avg_lvl = RD_W'(sum / cnt);     // truncates toward zero
                elapsed_cnt = elapsed_cnt - TICK_W'(period_cfg);
                r.accepted = 1'b1;
            end
            chg_flag = w.status[STAT_CHG_BIT];
            btn_flag = w.status[STAT_BTN_BIT];
        end
        r.average     = avg_lvl;
        r.charging    = chg_flag;
        r.button_down = btn_flag;
        return r;
    endfunction

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // battery-like values most of the time, failed reads and the full range too
    function automatic logic signed [RD_W-1:0] rand_reading();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7) return RD_W'($urandom_range(0, 100));
        if (r == 7) return -9'sd1;
        return RD_W'($urandom_range(0, 511));
    endfunction

    // ------------------------------------------------------------------
    // Clock, timeout
    // ------------------------------------------------------------------
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= RUN_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Driver: presents words from word_q, predicts on each handshake
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            send_hold = 0;
        end else begin
            if (i_valid && o_ready) begin
                level_q.push_back(predict_level(cur_word));
                send_hold = pick_gap();
            end else if (!i_valid && send_hold != 0) begin
                send_hold = send_hold - 1;
            end
            // slot is free once the current word is taken (or none is up)
            if (!i_valid || o_ready) begin
                if (send_hold == 0 && word_q.size() != 0) begin
                    cur_word = word_q.pop_front();
                    i_valid       <= 1'b1;
                    i_mode        <= cur_word.mode;
                    i_reading     <= cur_word.reading;
                    i_status_byte <= cur_word.status;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: random back-pressure, checks each result word in order
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            ready_hold <= 0;
        end else begin
            if (o_valid && i_ready) begin
                got_lvl.average     = o_average;
                got_lvl.charging    = o_charging;
                got_lvl.button_down = o_button_down;
                got_lvl.accepted    = o_accepted;
                if (level_q.size() == 0) begin
                    $error("result word with nothing expected: average %0d", o_average);
                    errors++;
                end else begin
                    exp_lvl = level_q.pop_front();
                    if (got_lvl.average !== exp_lvl.average) begin
                        $error("average: expected %0d, got %0d",
                               exp_lvl.average, got_lvl.average);
                        errors++;
                    end
                    if (got_lvl.charging !== exp_lvl.charging) begin
                        $error("charging: expected %0b, got %0b",
                               exp_lvl.charging, got_lvl.charging);
                        errors++;
                    end
                    if (got_lvl.button_down !== exp_lvl.button_down) begin
                        $error("button_down: expected %0b, got %0b",
                               exp_lvl.button_down, got_lvl.button_down);
                        errors++;
                    end
                    if (got_lvl.accepted !== exp_lvl.accepted) begin
                        $error("accepted: expected %0b, got %0b",
                               exp_lvl.accepted, got_lvl.accepted);
                        errors++;
                    end
                end
            end
            // stall pattern: a gap is drawn after each taken result
            if (ready_hold != 0) begin
                ready_hold <= ready_hold - 1;
                i_ready    <= (ready_hold == 1);
            end else if (o_valid && i_ready) begin
                ready_gap = pick_gap();
                ready_hold <= ready_gap;
                i_ready    <= (ready_gap == 0);
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic add_word(logic m, logic signed [RD_W-1:0] rd, logic [STAT_W-1:0] st);
        t_word w;
        w.mode    = m;
        w.reading = rd;
        w.status  = st;
        word_q.push_back(w);
    endtask

    // ticks carry random payload, which the block must ignore
    task automatic add_ticks(int n);
        for (int i = 0; i < n; i++)
            add_word(MODE_TICK, RD_W'($urandom_range(0, 511)), STAT_W'($urandom_range(0, 255)));
    endtask

    // every word yields a result, so an empty level_q means the block is idle
    task automatic wait_idle();
        while (word_q.size() != 0 || i_valid || level_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_period(logic [PERIOD_W-1:0] p);
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= p;
        period_cfg = p;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    initial begin
        int                  words_left;
        int                  n;
        int                  pick;
        logic [PERIOD_W-1:0] next_period;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset period: readings at zero elapsed are refused, flags still load
        add_word(MODE_READ, 9'sd100, 8'h81);
        add_word(MODE_TICK, -9'sd1, 8'hFF);
        add_word(MODE_READ, -9'sd1, 8'h00);
        wait_idle();

        // smallest period: full-scale reading, borderline refusal,
        // failed read and other negative readings counted when new
        write_period(16'd1);
        add_ticks(2);
        add_word(MODE_READ, 9'sd255, 8'h80);
        add_word(MODE_READ, 9'sd0, 8'h01);
        add_ticks(2);
        add_word(MODE_READ, -9'sd1, 8'h00);
        add_ticks(2);
        add_word(MODE_READ, -9'sd256, 8'hFE);
        add_ticks(2);
        add_word(MODE_READ, 9'sd37, 8'h7F);
        wait_idle();

        // zero period: any elapsed time above zero lets a reading in
        write_period(16'd0);
        add_ticks(1);
        add_word(MODE_READ, 9'sd5, 8'h01);
        add_word(MODE_READ, 9'sd6, 8'h80);
        wait_idle();

        // largest period: everything refused
        write_period(16'hFFFF);
        add_word(MODE_READ, 9'sd200, 8'h81);
        add_ticks(1);
        add_word(MODE_READ, 9'sd1, 8'h00);
        wait_idle();

        // random phases, each at its own period; mostly tick runs sized to
        // the period followed by a reading, plus stray words
        for (int ph = 0; ph < 10; ph++) begin
            case ($urandom_range(0, 9))
                0:       next_period = 16'd0;
                1:       next_period = 16'hFFFF;
                2:       next_period = PERIOD_RST;
                3, 4:    next_period = 16'd1;
                5:       next_period = PERIOD_W'($urandom_range(20, 60));
                default: next_period = PERIOD_W'($urandom_range(2, 6));
            endcase
            no_idle = ($urandom_range(0, 3) == 0);
            write_period(next_period);
            words_left = 200;
            while (words_left > 0) begin
                pick = $urandom_range(0, 9);
                if (pick < 7) begin
                    if (next_period <= 64)
                        n = int'(next_period) + $urandom_range(0, 2);
                    else
                        n = $urandom_range(0, 8);
                    add_ticks(n);
                    add_word(MODE_READ, rand_reading(), STAT_W'($urandom_range(0, 255)));
                    words_left -= n + 1;
                end else if (pick < 9) begin
                    add_word(1'($urandom_range(0, 1)), RD_W'($urandom_range(0, 511)),
                             STAT_W'($urandom_range(0, 255)));
                    words_left -= 1;
                end else begin
                    // readings back to back: later ones mostly refused
                    n = $urandom_range(2, 4);
                    for (int i = 0; i < n; i++)
                        add_word(MODE_READ, rand_reading(), STAT_W'($urandom_range(0, 255)));
                    words_left -= n;
                end
            end
            wait_idle();
        end

        no_idle = 1'b0;
        repeat (TAIL_WAIT) @(posedge i_clk);
        if (errors == 0 && level_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// File: battery_level_window_average.f
rtl/core/bwavg_pkg.sv
rtl/core/bwavg_ram.sv
rtl/core/bwavg_div.sv
rtl/core/battery_level_window_average.sv
bench/tb_battery_level_window_average.sv
